// ===== hdl/tkbd_pkg.sv =====
// Shared types and constants for the terminal key byte decoder.
// No dependencies.
package tkbd_pkg;

  typedef enum logic [2:0] {
    KIND_TEXT   = 3'd0,
    KIND_ARROW  = 3'd1,
    KIND_META   = 3'd2,
    KIND_CTRL   = 3'd3,
    KIND_RETURN = 3'd4,
    KIND_BACK   = 3'd5,
    KIND_BELL   = 3'd6
  } kind_t;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 21;

  localparam logic [7:0] BYTE_NUL   = 8'd0;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_CTRLZ = 8'd26;
  localparam logic [7:0] BYTE_ESC   = 8'd27;
  localparam logic [7:0] BYTE_SPACE = 8'd32;
  localparam logic [7:0] BYTE_DEL   = 8'd127;
  localparam logic [7:0] UTF_LEAD   = 8'd128;
  localparam logic [7:0] UTF_THREE  = 8'd224;
  localparam logic [7:0] UTF_FOUR   = 8'd240;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_D  = 8'h44;
  localparam logic [7:0] CHAR_UC_O  = 8'h4F;
  localparam logic [7:0] CHAR_BRACK = 8'h5B;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
  } event_t;

endpackage

// ===== hdl/tkbd_decode.sv =====
// Decoder state and per-byte decision logic: escape, arrow and UTF-8 tracking.
// Depends on tkbd_pkg.
module tkbd_decode (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [tkbd_pkg::BYTE_W-1:0]     key_byte,
  output tkbd_pkg::event_t                ev
);

  logic                            escape_seen, escape_seen_next;
  logic                            bracket_seen, bracket_seen_next;
  logic [2:0]                      utf_count, utf_count_next;
  logic [2:0]                      utf_width, utf_width_next;
  logic [tkbd_pkg::VALUE_W-1:0]    code_accum, code_accum_next;
  logic [tkbd_pkg::VALUE_W-1:0]    accum_shift;
  logic [2:0]                      count_inc;

  assign accum_shift = {code_accum[tkbd_pkg::VALUE_W-7:0], key_byte[5:0]};
  assign count_inc   = utf_count + 3'd1;

  always_comb begin
    escape_seen_next  = escape_seen;
    bracket_seen_next = bracket_seen;
    utf_count_next    = utf_count;
    utf_width_next    = utf_width;
    code_accum_next   = code_accum;
    ev.valid          = 1'b0;
    ev.kind           = tkbd_pkg::KIND_BELL;
    ev.value          = '0;
    if (escape_seen) begin
      if (bracket_seen) begin
        escape_seen_next  = 1'b0;
        bracket_seen_next = 1'b0;
        ev.valid          = 1'b1;
        if (key_byte >= tkbd_pkg::CHAR_UC_A && key_byte <= tkbd_pkg::CHAR_UC_D) begin
          ev.kind  = tkbd_pkg::KIND_ARROW;
          ev.value = tkbd_pkg::VALUE_W'(key_byte - tkbd_pkg::CHAR_UC_A);
        end
      end else if (key_byte >= tkbd_pkg::CHAR_LC_A && key_byte <= tkbd_pkg::CHAR_LC_Z) begin
        escape_seen_next = 1'b0;
        ev.valid         = 1'b1;
        ev.kind          = tkbd_pkg::KIND_META;
        ev.value         = tkbd_pkg::VALUE_W'(key_byte);
      end else if (key_byte == tkbd_pkg::CHAR_BRACK || key_byte == tkbd_pkg::CHAR_UC_O) begin
        bracket_seen_next = 1'b1;
      end else begin
        escape_seen_next = 1'b0;
        ev.valid         = 1'b1;
      end
    end else if (utf_width != 3'd0) begin
      // any byte inside an open sequence is a continuation
      if (count_inc >= utf_width) begin
        utf_count_next  = 3'd0;
        utf_width_next  = 3'd0;
        code_accum_next = '0;
        ev.valid        = 1'b1;
        ev.kind         = tkbd_pkg::KIND_TEXT;
        ev.value        = accum_shift;
      end else begin
        utf_count_next  = count_inc;
        code_accum_next = accum_shift;
      end
    end else if (key_byte >= tkbd_pkg::BYTE_SPACE && key_byte < tkbd_pkg::BYTE_DEL) begin
      ev.valid = 1'b1;
      ev.kind  = tkbd_pkg::KIND_TEXT;
      ev.value = tkbd_pkg::VALUE_W'(key_byte);
    end else if (key_byte == tkbd_pkg::BYTE_NUL) begin
      ev.valid = 1'b1;
    end else if (key_byte == tkbd_pkg::BYTE_CR) begin
      ev.valid = 1'b1;
      ev.kind  = tkbd_pkg::KIND_RETURN;
    end else if (key_byte <= tkbd_pkg::BYTE_CTRLZ) begin
      ev.valid = 1'b1;
      ev.kind  = tkbd_pkg::KIND_CTRL;
      ev.value = tkbd_pkg::VALUE_W'(key_byte + (tkbd_pkg::CHAR_LC_A - 8'd1));
    end else if (key_byte == tkbd_pkg::BYTE_ESC) begin
      escape_seen_next  = 1'b1;
      bracket_seen_next = 1'b0;
    end else if (key_byte == tkbd_pkg::BYTE_DEL) begin
      ev.valid = 1'b1;
      ev.kind  = tkbd_pkg::KIND_BACK;
    end else if (key_byte >= tkbd_pkg::UTF_LEAD) begin
      utf_count_next = 3'd1;
      if (key_byte < tkbd_pkg::UTF_THREE) begin
        utf_width_next  = 3'd2;
        code_accum_next = tkbd_pkg::VALUE_W'(key_byte[4:0]);
      end else if (key_byte < tkbd_pkg::UTF_FOUR) begin
        utf_width_next  = 3'd3;
        code_accum_next = tkbd_pkg::VALUE_W'(key_byte[3:0]);
      end else begin
        utf_width_next  = 3'd4;
        code_accum_next = tkbd_pkg::VALUE_W'(key_byte[2:0]);
      end
    end
    // bytes 28..31 fall through: no event, no state change
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_seen  <= 1'b0;
      bracket_seen <= 1'b0;
      utf_count    <= 3'd0;
      utf_width    <= 3'd0;
      code_accum   <= '0;
    end else if (step) begin
      escape_seen  <= escape_seen_next;
      bracket_seen <= bracket_seen_next;
      utf_count    <= utf_count_next;
      utf_width    <= utf_width_next;
      code_accum   <= code_accum_next;
    end
  end

endmodule

// ===== hdl/terminal_key_byte_decoder.sv =====
// Top level of the terminal key byte decoder: input register, decoder, result register.
// Depends on tkbd_pkg and tkbd_decode.
//
// Usage:
//   s_* channel carries one raw terminal byte per transfer (s_tdata[7:0]).
//   m_* channel carries one key event per transfer: m_tdata[2:0] kind,
//   m_tdata[23:3] value (code point, arrow code or ASCII letter, else 0).
//   A byte gives zero or one event; escape prefixes, '['/'O' after escape,
//   UTF-8 lead and middle bytes and bytes 28..31 give none.
//   An event reaches m_tvalid after its last byte transfers: the byte
//   sits in the input register, and the decoded event is then loaded
//   into the result register.
//   Throughput: one byte per cycle while m_tready is high; the decoder
//   state update is a single byte-wide decision between the two registers.
//   Stall: with m_tready low the result register holds and one more byte
//   is held in the input register; then s_tready drops.
//   Reset (rst, synchronous): empties both registers and returns the
//   decoder to its plain state (no escape, no open UTF-8 sequence).
module terminal_key_byte_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] key_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [2:0] event_kind, [23:3] event_value
);

  logic                         in_valid;
  logic [tkbd_pkg::BYTE_W-1:0]  in_byte;
  logic                         advance;
  tkbd_pkg::event_t             ev;
  tkbd_pkg::kind_t              out_kind;
  logic [tkbd_pkg::VALUE_W-1:0] out_value;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  tkbd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .key_byte (in_byte),
    .ev       (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= ev.valid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
    if (advance && ev.valid) begin
      out_kind  <= ev.kind;
      out_value <= ev.value;
    end
  end

  assign m_tdata = {out_value, out_kind};

  // Kinds without a payload carry zero.
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_kind == tkbd_pkg::KIND_RETURN || out_kind == tkbd_pkg::KIND_BACK ||
                 out_kind == tkbd_pkg::KIND_BELL) |-> out_value == '0)
    else $error("payload-free event with nonzero value");

  a_arrow_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_kind == tkbd_pkg::KIND_ARROW |-> out_value < 21'd4)
    else $error("arrow code out of range");

  // Input side only backs up when a byte is actually waiting.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a pending byte");

  // A waiting result is not overwritten.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

// ===== bench/tkbd_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard for the terminal key byte decoder: predicts key events from raw bytes.
// Depends on tkbd_pkg for the event kinds and byte constants.
package tkbd_sb_pkg;
  import tkbd_pkg::*;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
  } key_event_t;

  class key_event_scoreboard;
    key_event_t         expected_events[$];
    int unsigned        errors;
    bit                 esc_open;
    bit                 bracket_open;
    logic [2:0]         utf_taken;
    logic [2:0]         utf_len;
    logic [VALUE_W-1:0] code_point;

    function new();
      errors       = 0;
      esc_open     = 0;
      bracket_open = 0;
      utf_taken    = '0;
      utf_len      = '0;
      code_point   = '0;
    endfunction

    function void push_event(kind_t k, logic [VALUE_W-1:0] v);
      key_event_t ev;
      ev.kind  = k;
      ev.value = v;
      expected_events.push_back(ev);
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    // Called for every byte transfer on the input side.
    function void note_byte(logic [7:0] b);
      if (esc_open) begin
        if (bracket_open) begin
          esc_open     = 0;
          bracket_open = 0;
          if (b >= CHAR_UC_A && b <= CHAR_UC_D)
            push_event(KIND_ARROW, VALUE_W'(b - CHAR_UC_A));
          else
            push_event(KIND_BELL, '0);
        end else if (b >= CHAR_LC_A && b <= CHAR_LC_Z) begin
          esc_open = 0;
          push_event(KIND_META, VALUE_W'(b));
        end else if (b == CHAR_BRACK || b == CHAR_UC_O) begin
          bracket_open = 1;
        end else begin
          esc_open = 0;
          push_event(KIND_BELL, '0);
        end
      end else if (utf_len != 3'd0) begin
        // any byte counts as continuation, escape included
        code_point = {code_point[VALUE_W-7:0], b[5:0]};
        utf_taken  = utf_taken + 3'd1;
        if (utf_taken >= utf_len) begin
          push_event(KIND_TEXT, code_point);
          utf_taken  = '0;
          utf_len    = '0;
          code_point = '0;
        end
      end else if (b >= BYTE_SPACE && b < BYTE_DEL) begin
        push_event(KIND_TEXT, VALUE_W'(b));
      end else if (b == BYTE_NUL) begin
        push_event(KIND_BELL, '0);
      end else if (b == BYTE_CR) begin
        push_event(KIND_RETURN, '0);
      end else if (b <= BYTE_CTRLZ) begin
        push_event(KIND_CTRL, VALUE_W'(CHAR_LC_A + b - 8'd1));
      end else if (b == BYTE_ESC) begin
        esc_open     = 1;
        bracket_open = 0;
      end else if (b == BYTE_DEL) begin
        push_event(KIND_BACK, '0);
      end else if (b >= UTF_LEAD) begin
        utf_taken = 3'd1;
        if (b < UTF_THREE) begin
          utf_len    = 3'd2;
          code_point = VALUE_W'(b[4:0]);
        end else if (b < UTF_FOUR) begin
          utf_len    = 3'd3;
          code_point = VALUE_W'(b[3:0]);
        end else begin
          utf_len    = 3'd4;
          code_point = VALUE_W'(b[2:0]);
        end
      end
      // 28..31 fall through: nothing happens
    endfunction

    // Called for every event transfer on the output side.
    function void check_event(logic [23:0] word);
      key_event_t exp_ev;
      logic [2:0]         got_kind;
      logic [VALUE_W-1:0] got_value;
      got_kind  = word[2:0];
      got_value = word[23:3];
      if (expected_events.size() == 0) begin
        $error("unexpected event: event_kind %0d event_value %0d", got_kind, got_value);
        errors++;
        return;
      end
      exp_ev = expected_events.pop_front();
      if (got_kind != exp_ev.kind) begin
        $error("event_kind: expected %0d actual %0d", exp_ev.kind, got_kind);
        errors++;
      end
      if (got_value != exp_ev.value) begin
        $error("event_value: expected %0d actual %0d", exp_ev.value, got_value);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for terminal_key_byte_decoder: random stream stimulus, stalls, scoreboard.
// Depends on tkbd_pkg, tkbd_sb_pkg and the decoder RTL.
module tb_top;
  import tkbd_pkg::*;
  import tkbd_sb_pkg::*;

  localparam int unsigned RANDOM_BYTES = 2000;
  localparam int unsigned QUIET_AFTER  = 1700;
  localparam int unsigned HOLD_AT      = 1000;
  localparam int unsigned STALL_LIMIT  = 1000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] key_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [2:0] event_kind, [23:3] event_value

  key_event_scoreboard sb;
  bit          quiet;
  int unsigned stall_cycles;
  int unsigned bytes_sent;
  bit          held;

  terminal_key_byte_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // transfers are taken on the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata);
      if (m_tvalid && m_tready) sb.check_event(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("tb: failure");
    $finish;
  end

  // receiver: random stall bursts until the quiet tail
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      m_tready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      s_tdata  = 8'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (!(b >= 8'd28 && b <= 8'd31)) bytes_sent++;
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  task automatic send_random_group();
    logic [7:0] bracket;
    int n;
    bracket = ($urandom_range(0, 1) == 1) ? CHAR_BRACK : CHAR_UC_O;
    case ($urandom_range(0, 9))
      0: send_byte(8'($urandom_range(32, 126)));
      1: begin
        if ($urandom_range(0, 7) == 0) send_byte(BYTE_DEL);
        else send_byte(8'($urandom_range(0, 31)));
      end
      2: begin
        send_byte(BYTE_ESC);
        send_byte(8'($urandom_range(CHAR_LC_A, CHAR_LC_Z)));
      end
      3: begin
        send_byte(BYTE_ESC);
        send_byte(bracket);
        send_byte(8'($urandom_range(CHAR_UC_A, CHAR_UC_D)));
      end
      4: begin
        // broken arrow sequence
        send_byte(BYTE_ESC);
        send_byte(bracket);
        send_byte(8'($urandom));
      end
      5: begin
        send_byte(BYTE_ESC);
        send_byte(8'($urandom));
      end
      6: begin
        send_byte(8'($urandom_range(8'hC0, 8'hDF)));
        send_byte(cont_byte());
      end
      7: begin
        send_byte(8'($urandom_range(UTF_THREE, 8'hEF)));
        repeat (2) send_byte(cont_byte());
      end
      8: begin
        send_byte(8'($urandom_range(UTF_FOUR, 8'hF7)));
        repeat (3) send_byte(cont_byte());
      end
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) send_byte(8'($urandom));
      end
    endcase
  endtask

  initial begin
    logic [7:0] directed[$];
    sb         = new();
    quiet      = 0;
    held       = 0;
    bytes_sent = 0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = 8'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // extremes of the plain bytes, escapes, lead widths, escape inside a sequence
    directed = '{8'd0, 8'd1, 8'd13, 8'd26, 8'd28, 8'd32, 8'd126, 8'd127,
                 BYTE_ESC, CHAR_LC_Z,
                 BYTE_ESC, CHAR_BRACK, 8'h42,
                 BYTE_ESC, CHAR_UC_O, 8'h78,
                 BYTE_ESC, 8'h35,
                 8'hDF, 8'hBF,
                 8'hEF, BYTE_ESC, 8'hFF,
                 8'hFF, 8'h00, 8'h80, 8'h7F};
    foreach (directed[i]) send_byte(directed[i]);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (!held && bytes_sent >= HOLD_AT) begin
        held     = 1;
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      if (bytes_sent >= QUIET_AFTER) quiet = 1;
      send_random_group();
    end
    s_tvalid = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tkbd_pkg.sv
hdl/tkbd_decode.sv
hdl/terminal_key_byte_decoder.sv
bench/tkbd_scoreboard.sv
bench/tb_top.sv
